@@ hw/rtl/lsba_pkg.sv @@
// Package for the logic sample byte assembler.
// Holds the payload, configuration and register-index types shared by all files.
// No dependencies.
package lsba_pkg;

  localparam int BYTE_W          = 8;
  localparam int WORD_W          = 32;
  localparam int SLOT_W          = 24;
  localparam int GE_W            = 8;
  localparam int HELD_W          = 4;
  localparam int GROUPS_PER_WORD = WORD_W / BYTE_W;

  localparam logic [GE_W-1:0]   GE_RESET    = 8'hff;
  localparam logic [SLOT_W-1:0] LIMIT_RESET = 24'd4096;

  typedef enum logic [0:0] {
    REG_GROUP_ENABLE = 1'b0,
    REG_SAMPLE_LIMIT = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [BYTE_W-1:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic              word_index;
    logic [WORD_W-1:0] sample_word;
    logic [SLOT_W-1:0] store_slot;
    logic              last_word;
  } out_item_t;

  typedef struct packed {
    cfg_reg_t          reg_index;
    logic [SLOT_W-1:0] wdata;
  } cfg_item_t;

  typedef struct packed {
    logic [GE_W-1:0]   group_enable;
    logic [SLOT_W-1:0] sample_limit;
  } cfg_t;

endpackage

@@ hw/rtl/lsba_in_if.sv @@
// Input channel of the sample byte assembler: valid/ready plus one received byte.
// Depends on lsba_pkg.
interface lsba_in_if;
  logic               valid;
  logic               ready;
  lsba_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ hw/rtl/lsba_out_if.sv @@
// Result channel of the sample byte assembler: valid/ready plus one sample word.
// Depends on lsba_pkg.
interface lsba_out_if;
  logic                valid;
  logic                ready;
  lsba_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ hw/rtl/lsba_cfg_if.sv @@
// Configuration write channel: valid/ready plus register index and write data.
// Depends on lsba_pkg.
interface lsba_cfg_if;
  logic                valid;
  logic                ready;
  lsba_pkg::cfg_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ hw/rtl/logic_sample_byte_assembler.sv @@
// Logic sample byte assembler: turns link bytes of enabled channel groups into
// full samples sent as 32-bit words.
// Depends on lsba_pkg, the three channel interfaces, lsba_cfg_regs,
// lsba_collect and lsba_serial.
//
// Usage:
//   in_ch  : one received byte per item, one byte per enabled 8-channel group.
//   out_ch : NUM_WORDS items per completed sample, little-endian words with
//            disabled groups zero, tagged with the reversed store slot; the
//            last word of a sample has last_word set.
//   cfg_ch : register 0 = group enable mask, register 1 = sample limit.
//            Always ready; write only while no sample is in flight.
// Latency: the first word of a sample is valid the cycle after the byte that
//   completes it is taken; following words go one per cycle while out_ch is ready.
// Throughput: one byte per cycle except as held off below. A sample occupies the
//   output word register until its last word is taken, so a byte that completes
//   the next sample is held off until then; other bytes never stall.
// Reset (rst_n low, synchronous): mask all ones, limit 4096, no partial
//   sample, sample count zero, output empty.
// Receiver stall: the word on out_ch holds until taken; input keeps flowing
//   until a completing byte needs the output register.
// Once the sample count reaches the limit, or with no group enabled, bytes are
//   taken and dropped.
module logic_sample_byte_assembler #(
  parameter int NUM_WORDS = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  lsba_in_if.sink     in_ch,
  lsba_out_if.source  out_ch,
  lsba_cfg_if.sink    cfg_ch
);
  import lsba_pkg::*;

  cfg_t                          cfg;
  logic                          smp_valid;
  logic                          smp_ready;
  logic [NUM_WORDS*WORD_W-1:0]   smp_bytes;
  logic [SLOT_W-1:0]             smp_slot;

  // configuration register file
  lsba_cfg_regs u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  // byte gathering, sample count, group expansion
  lsba_collect #(
    .NUM_WORDS (NUM_WORDS)
  ) u_collect (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_ch     (in_ch),
    .smp_valid (smp_valid),
    .smp_ready (smp_ready),
    .smp_bytes (smp_bytes),
    .smp_slot  (smp_slot)
  );

  // sample register and word output
  lsba_serial #(
    .NUM_WORDS (NUM_WORDS)
  ) u_serial (
    .clk       (clk),
    .rst_n     (rst_n),
    .smp_valid (smp_valid),
    .smp_ready (smp_ready),
    .smp_bytes (smp_bytes),
    .smp_slot  (smp_slot),
    .out_ch    (out_ch)
  );

endmodule

@@ hw/rtl/lsba_cfg_regs.sv @@
// Configuration registers: group enable mask and sample limit.
// Depends on lsba_pkg and lsba_cfg_if.
module lsba_cfg_regs (
  input  logic             clk,
  input  logic             rst_n,
  lsba_cfg_if.sink         cfg_ch,
  output lsba_pkg::cfg_t   cfg
);
  import lsba_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  assign cfg_ch.ready = 1'b1;
  assign cfg          = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_ch.valid) begin
      unique case (cfg_ch.data.reg_index)
        REG_GROUP_ENABLE: cfg_nxt.group_enable = cfg_ch.data.wdata[GE_W-1:0];
        REG_SAMPLE_LIMIT: cfg_nxt.sample_limit = cfg_ch.data.wdata;
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.group_enable <= GE_RESET;
      cfg_r.sample_limit <= LIMIT_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

@@ hw/rtl/lsba_collect.sv @@
// Byte collector: gathers one byte per enabled group, counts samples, and on
// completion hands the expanded sample and its slot to the serializer.
// Depends on lsba_pkg and lsba_in_if.
module lsba_collect #(
  parameter int NUM_WORDS = 2
) (
  input  logic                                           clk,
  input  logic                                           rst_n,
  input  lsba_pkg::cfg_t                                 cfg,
  lsba_in_if.sink                                        in_ch,
  output logic                                           smp_valid,
  input  logic                                           smp_ready,
  output logic [NUM_WORDS*lsba_pkg::WORD_W-1:0]          smp_bytes,
  output logic [lsba_pkg::SLOT_W-1:0]                    smp_slot
);
  import lsba_pkg::*;

  localparam int NG   = NUM_WORDS * GROUPS_PER_WORD;
  localparam int SD   = (NG < GE_W) ? NG : GE_W;   // only enabled groups are stored
  localparam int SD_W = $clog2(SD);

  logic [BYTE_W-1:0] store_r   [SD];
  logic [BYTE_W-1:0] store_nxt [SD];
  logic [HELD_W-1:0] held_r, held_nxt, held_inc;
  logic [SLOT_W-1:0] done_r, done_nxt, done_inc;

  logic [NG+GE_W-1:0] ge_ext;
  logic [NG-1:0]      grp_on;
  logic [HELD_W-1:0]  rank [NG];
  logic [HELD_W-1:0]  need;
  logic               blocked, completes, accept;

  assign ge_ext = {NG'(0), cfg.group_enable};
  assign grp_on = ge_ext[NG-1:0];

  // running count of enabled groups below each group gives its byte slot
  always_comb begin
    need = '0;
    for (int g = 0; g < NG; g++) begin
      rank[g] = need;
      need    = need + HELD_W'(grp_on[g]);
    end
  end

  assign held_inc  = held_r + HELD_W'(1);
  assign done_inc  = done_r + SLOT_W'(1);
  assign blocked   = (done_r >= cfg.sample_limit) || (need == '0);
  assign completes = !blocked && (held_inc >= need);

  // a completing byte waits for the serializer; others never stall
  assign in_ch.ready = !completes || smp_ready;
  assign accept      = in_ch.valid && in_ch.ready;

  always_comb begin
    store_nxt = store_r;
    if (accept && !blocked) store_nxt[held_r[SD_W-1:0]] = in_ch.data.rx_byte;
  end

  always_comb begin
    smp_bytes = '0;
    for (int g = 0; g < NG; g++) begin
      if (grp_on[g]) smp_bytes[g*BYTE_W +: BYTE_W] = store_nxt[rank[g][SD_W-1:0]];
    end
  end

  assign smp_valid = accept && completes;
  assign smp_slot  = cfg.sample_limit - done_inc;

  always_comb begin
    held_nxt = held_r;
    done_nxt = done_r;
    if (accept && !blocked) begin
      if (completes) begin
        held_nxt = '0;
        done_nxt = done_inc;
      end else begin
        held_nxt = held_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= '0;
      done_r <= '0;
    end else begin
      held_r <= held_nxt;
      done_r <= done_nxt;
    end
  end

  // byte store is payload: entries are always written before they are read
  always_ff @(posedge clk) begin
    store_r <= store_nxt;
  end

endmodule

@@ hw/rtl/lsba_serial.sv @@
// Word serializer: holds one expanded sample and sends it one 32-bit word per item.
// Depends on lsba_pkg and lsba_out_if.
module lsba_serial #(
  parameter int NUM_WORDS = 2
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  smp_valid,
  output logic                                  smp_ready,
  input  logic [NUM_WORDS*lsba_pkg::WORD_W-1:0] smp_bytes,
  input  logic [lsba_pkg::SLOT_W-1:0]           smp_slot,
  lsba_out_if.source                            out_ch
);
  import lsba_pkg::*;

  localparam int WC_W = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;

  logic [NUM_WORDS-1:0][WORD_W-1:0] sample_r;
  logic [SLOT_W-1:0]                slot_r;
  logic                             busy_r, busy_nxt;
  logic [WC_W-1:0]                  cnt_r, cnt_nxt;
  logic                             last, take, load;

  assign last      = (cnt_r == WC_W'(NUM_WORDS - 1));
  assign take      = busy_r && out_ch.ready;
  assign smp_ready = !busy_r || (out_ch.ready && last);
  assign load      = smp_valid && smp_ready;

  assign out_ch.valid            = busy_r;
  assign out_ch.data.word_index  = cnt_r[0];
  assign out_ch.data.sample_word = sample_r[cnt_r];
  assign out_ch.data.store_slot  = slot_r;
  assign out_ch.data.last_word   = last;

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    if (load) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
    end else if (take) begin
      if (last) busy_nxt = 1'b0;
      else      cnt_nxt  = cnt_r + WC_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      sample_r <= smp_bytes;
      slot_r   <= smp_slot;
    end
  end

endmodule

@@ sim/tb_logic_sample_byte_assembler.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for logic_sample_byte_assembler: random and directed link bytes
// against a cycle-free sample predictor. Needs lsba_pkg, the three channel interfaces and the RTL.
module tb_logic_sample_byte_assembler;
  import lsba_pkg::*;

  localparam int WORDS         = 2;
  localparam int NGRP          = WORDS * GROUPS_PER_WORD;
  localparam int IDLE_PCT      = 36;
  localparam int HOLD_CYCLES   = 80;    // one long receiver hold-off
  localparam int SETTLE_CYCLES = 4;     // extra wait for a partial sample once every word is back
  localparam int WATCHDOG      = 4000;  // cycles with no handshake at all
  localparam int TARGET_BYTES  = 500;

  logic clk = 1'b0;
  logic rst_n;

  always #6 clk = ~clk;

  lsba_in_if  in_ch ();
  lsba_out_if out_ch ();
  lsba_cfg_if cfg_ch ();

  logic_sample_byte_assembler #(.NUM_WORDS(WORDS)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // Predictor state: register copies plus the sample being gathered.
  logic [GE_W-1:0]   grp_mask = GE_RESET;
  logic [SLOT_W-1:0] cap_limit = LIMIT_RESET;
  logic [BYTE_W-1:0] gathered [NGRP];
  logic [HELD_W-1:0] gathered_cnt = '0;
  logic [SLOT_W-1:0] sample_cnt = '0;

  logic [BYTE_W-1:0] pending_bytes [$];   // link bytes waiting for the driver
  out_item_t         expected_words [$];  // predicted sample words, oldest first

  // Run control, written by the stimulus block only.
  bit fast_mode = 1'b0;   // no idling on either side
  bit long_hold = 1'b0;   // ask the receiver for its long hold-off

  int errors       = 0;
  int used_bytes   = 0;
  int dropped      = 0;
  int samples_seen = 0;
  int words_ok     = 0;
  int reg_writes   = 0;
  int quiet_cycles = 0;
  int hold_count   = 0;
  bit hold_done    = 1'b0;

  initial begin
    for (int i = 0; i < NGRP; i++) gathered[i] = '0;
  end

  // Expand one accepted link byte; queue the sample words it completes.
  task automatic absorb_byte(input logic [BYTE_W-1:0] b);
    logic [BYTE_W-1:0] full [NGRP];
    logic [SLOT_W-1:0] slot;
    out_item_t         w;
    int                need;
    int                j;
    need = $countones(grp_mask);
    // limit reached, or nothing enabled: byte is swallowed
    if (sample_cnt >= cap_limit || need == 0) begin
      dropped++;
      return;
    end
    used_bytes++;
    if (gathered_cnt < NGRP) gathered[gathered_cnt] = b;
    gathered_cnt = gathered_cnt + 1'b1;
    if (gathered_cnt < need) return;

    sample_cnt = sample_cnt + 1'b1;
    slot = cap_limit - sample_cnt;
    // held bytes fill enabled groups in ascending order; extras fall away
    j = 0;
    for (int g = 0; g < NGRP; g++) begin
      if (g < GE_W && grp_mask[g % GE_W] && j < NGRP) begin
        full[g] = gathered[j];
        j++;
      end else begin
        full[g] = '0;
      end
    end
    for (int n = 0; n < WORDS; n++) begin
      w.word_index  = n[0];
      w.sample_word = {full[4*n+3], full[4*n+2], full[4*n+1], full[4*n]};
      w.store_slot  = slot;
      w.last_word   = (n == WORDS - 1);
      expected_words.push_back(w);
    end
    for (int i = 0; i < NGRP; i++) gathered[i] = '0;
    gathered_cnt = '0;
    samples_seen++;
  endtask

  task automatic flag_field(input string field, input logic [31:0] want,
                            input logic [31:0] got);
    errors++;
    if (errors <= 40)
      $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, field, want, got);
  endtask

  task automatic check_word(input out_item_t got);
    out_item_t want;
    if (expected_words.size() == 0) begin
      errors++;
      if (errors <= 40)
        $display("%0t: unexpected word, expected none, got 0x%08h slot %0d",
                 $time, got.sample_word, got.store_slot);
      return;
    end
    want = expected_words.pop_front();
    if (got.word_index !== want.word_index)
      flag_field("word_index", want.word_index, got.word_index);
    if (got.sample_word !== want.sample_word)
      flag_field("sample_word", want.sample_word, got.sample_word);
    if (got.store_slot !== want.store_slot)
      flag_field("store_slot", want.store_slot, got.store_slot);
    if (got.last_word !== want.last_word)
      flag_field("last_word", want.last_word, got.last_word);
    if (got === want) words_ok++;
  endtask

  // Byte driver: holds an item until taken, idles at random between items.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) absorb_byte(in_ch.data.rx_byte);
      if (!in_ch.valid || in_ch.ready) begin
        if (pending_bytes.size() != 0 &&
            (fast_mode || $urandom_range(0, 99) >= IDLE_PCT)) begin
          in_ch.valid <= 1'b1;
          in_ch.data  <= pending_bytes.pop_front();
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Word monitor: checks every taken word, drives ready with random stalls.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) check_word(out_ch.data);
      if (long_hold && !hold_done) begin
        // long back-pressure: the block fills and must stall its byte input
        out_ch.ready <= 1'b0;
        hold_count++;
        if (hold_count >= HOLD_CYCLES) hold_done = 1'b1;
      end else if (fast_mode) begin
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  // Watchdog: any handshake counts as progress.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG) begin
      $display("%0t: watchdog, no handshake for %0d cycles", $time, WATCHDOG);
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Register write; only called with nothing in flight.
  task automatic write_reg(input cfg_reg_t idx, input logic [SLOT_W-1:0] val);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= '{reg_index: idx, wdata: val};
    do @(posedge clk); while (!(cfg_ch.valid && cfg_ch.ready));
    cfg_ch.valid <= 1'b0;
    if (idx == REG_GROUP_ENABLE) grp_mask = val[GE_W-1:0];
    else cap_limit = val;
    reg_writes++;
  endtask

  // Wait until every byte is taken and every word has come back, then let
  // a partial sample that produced nothing settle inside the block.
  task automatic settle();
    while (pending_bytes.size() != 0 || in_ch.valid || expected_words.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic send_bytes(input logic [BYTE_W-1:0] seq [$]);
    foreach (seq[i]) pending_bytes.push_back(seq[i]);
    settle();
  endtask

  initial begin
    int                need;
    int                nitems;
    logic [SLOT_W-1:0] new_limit;
    rst_n        = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data  = '{reg_index: REG_GROUP_ENABLE, wdata: '0};
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // --- directed part ---
    // all groups at reset values: byte extremes in one full sample
    send_bytes('{8'h00, 8'hff, 8'h01, 8'h80, 8'haa, 8'h55, 8'h7f, 8'hfe});
    // no group enabled: bytes vanish
    write_reg(REG_GROUP_ENABLE, 24'h00);
    send_bytes('{8'hff, 8'h5a});
    // lowest and highest single group
    write_reg(REG_GROUP_ENABLE, 24'h01);
    send_bytes('{8'hc3, 8'h3c});
    write_reg(REG_GROUP_ENABLE, 24'h80);
    send_bytes('{8'h99});
    // enables shrink under a partial sample: next byte completes, extra dropped
    write_reg(REG_GROUP_ENABLE, 24'ha5);
    send_bytes('{8'h11, 8'h22});
    write_reg(REG_GROUP_ENABLE, 24'h03);
    send_bytes('{8'h33});
    // enables grow under a partial sample
    write_reg(REG_GROUP_ENABLE, 24'h0f);
    send_bytes('{8'h44, 8'h55, 8'h66});
    write_reg(REG_GROUP_ENABLE, 24'hff);
    send_bytes('{8'h77, 8'h88, 8'h99, 8'hab, 8'hcd});
    // limit already reached
    write_reg(REG_SAMPLE_LIMIT, sample_cnt);
    send_bytes('{8'h12});
    // one sample left: slot zero, then capture stops
    write_reg(REG_GROUP_ENABLE, 24'h01);
    write_reg(REG_SAMPLE_LIMIT, sample_cnt + 1'b1);
    send_bytes('{8'hed, 8'hfe});

    // --- random phases: mostly whole samples, some ragged ones ---
    for (int p = 0; used_bytes + dropped < TARGET_BYTES && p < 200; p++) begin
      if (p == 0 || p == 2 || p == 4) begin
        write_reg(REG_GROUP_ENABLE, 24'hff);
        write_reg(REG_SAMPLE_LIMIT, 24'hffffff);
      end else begin
        if ($urandom_range(0, 3) != 0) begin
          case ($urandom_range(0, 9))
            0:       write_reg(REG_GROUP_ENABLE, 24'hff);
            1:       write_reg(REG_GROUP_ENABLE, 24'(1 << $urandom_range(0, 7)));
            2:       write_reg(REG_GROUP_ENABLE, 24'h00);
            default: write_reg(REG_GROUP_ENABLE, 24'($urandom_range(1, 255)));
          endcase
        end
        if (sample_cnt >= cap_limit || $urandom_range(0, 3) == 0) begin
          case ($urandom_range(0, 5))
            0:       new_limit = 24'hffffff;
            1:       new_limit = 24'd1;
            2:       new_limit = sample_cnt + 24'($urandom_range(1, 8));
            default: new_limit = 24'($urandom_range(int'(sample_cnt) + 64, 24'hffffff));
          endcase
          write_reg(REG_SAMPLE_LIMIT, new_limit);
        end
      end
      fast_mode = (p == 2);
      long_hold = (p == 4);
      need = $countones(grp_mask);
      nitems = (need == 0) ? 12 : need * $urandom_range(3, 10);
      if ($urandom_range(0, 3) == 0) nitems += $urandom_range(1, 7);
      // full-rate phase runs long enough to stream many samples without a gap
      if (fast_mode) nitems = need * 16;
      repeat (nitems) pending_bytes.push_back(8'($urandom_range(0, 255)));
      settle();
    end
    fast_mode = 1'b0;
    long_hold = 1'b0;

    settle();
    repeat (8) @(posedge clk);
    if (expected_words.size() != 0) begin
      errors++;
      $display("%0t: %0d expected words never arrived", $time, expected_words.size());
    end
    $display("Fed %0d sample bytes (%0d more dropped), %0d samples, %0d words matched,",
             used_bytes, dropped, samples_seen, words_ok);
    $display("%0d register writes incl. limit stop and enable changes mid-sample", reg_writes);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
